// ===== sv/coulomb_friction_return_map_assert.svh =====
// Assertion shorthands for the friction return map checks.
`ifndef COULOMB_FRICTION_RETURN_MAP_ASSERT_SVH
`define COULOMB_FRICTION_RETURN_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define CFRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define CFRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cfrm_pkg.sv =====
package cfrm_pkg;

  localparam int NUM_DIMS = 3;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DIMS      = 2'd1;

  localparam int TIME_STEP_RESET = 66;
  localparam logic [1:0] DIMS_RESET = 2'd3;

  typedef struct packed {
    logic vld;
    logic slide;
    logic stick;
  } cfrm_ctl_t;

endpackage

// ===== sv/cfrm_front.sv =====
module cfrm_front
  import cfrm_pkg::*;
#(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_vld_i,
  input  logic                               contact_i,
  input  logic [1:0]                         dims_i,
  input  logic [DW-2:0]                      time_step_i,
  input  logic [DW-2:0]                      imp_i,
  input  logic [DW-2:0]                      str_i,
  input  logic [NUM_DIMS-1:0][DW-1:0]        vel_i,
  input  logic [NUM_DIMS-1:0][DW-1:0]        acc_i,
  input  logic [NUM_DIMS-1:0][DW-1:0]        old_i,
  output logic [NUM_DIMS-1:0][DW-1:0]        t_o,
  output logic [NUM_DIMS-1:0][2*DW-2:0]      num_o,
  output logic [2*DW-1:0]                    sum_o,
  output cfrm_ctl_t                          ctl_o
);

  localparam logic [2*DW-1:0] LIM_NEG = (2*DW)'(1) << (DW-1);
  localparam logic [2*DW-1:0] LIM_POS = LIM_NEG - (2*DW)'(1);
  localparam logic [DW-1:0]   SMIN    = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]   SMAX    = {1'b0, {(DW-1){1'b1}}};

  function automatic logic [DW-1:0] mag_f(logic [DW-1:0] x);
    mag_f = x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [DW-1:0] sat_mag_f(logic neg, logic [2*DW-1:0] m);
    if (neg) sat_mag_f = (m > LIM_NEG) ? SMIN : (~m[DW-1:0] + 1'b1);
    else     sat_mag_f = (m > LIM_POS) ? SMAX : m[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sat_add_f(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    sat_add_f = (s[DW] != s[DW-1]) ? (s[DW] ? SMIN : SMAX) : s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] sat_sub_f(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    sat_sub_f = (s[DW] != s[DW-1]) ? (s[DW] ? SMIN : SMAX) : s[DW-1:0];
  endfunction

  logic [5:0] vld_q;
  logic [5:0] contact_q;

  logic [NUM_DIMS-1:0][2*DW-2:0] s1_pa_q, s1_po_q;
  logic [NUM_DIMS-1:0]           s1_na_q, s1_no_q, s1_used_q;
  logic [NUM_DIMS-1:0][DW-1:0]   s1_vel_q;
  logic [DW-2:0]                 s1_imp_q, s1_str_q;

  logic [NUM_DIMS-1:0][DW-1:0]   s2_g_q;
  logic [NUM_DIMS-1:0]           s2_used_q;
  logic [DW-2:0]                 s2_imp_q, s2_str_q;

  logic [NUM_DIMS-1:0][2*DW-2:0] s3_pg_q;
  logic [NUM_DIMS-1:0]           s3_ng_q, s3_used_q;
  logic [DW-2:0]                 s3_str_q;

  logic [NUM_DIMS-1:0][DW-1:0]   s4_t_q;
  logic [DW-2:0]                 s4_str_q;

  logic [NUM_DIMS-1:0][2*DW-1:0] s5_sq_q;
  logic [NUM_DIMS-1:0][2*DW-2:0] s5_num_q;
  logic [2*DW-3:0]               s5_ssq_q;
  logic [NUM_DIMS-1:0][DW-1:0]   s5_t_q;

  logic [2*DW-1:0]               sum_d, sum_q;
  logic [NUM_DIMS-1:0][DW-1:0]   t_q;
  logic [NUM_DIMS-1:0][2*DW-2:0] num_q;
  logic                          slide_d, slide_q, stick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      contact_q <= '0;
    end else if (en_i) begin
      vld_q     <= {vld_q[4:0], in_vld_i};
      contact_q <= {contact_q[4:0], contact_i};
    end
  end

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < NUM_DIMS; d++) sum_d = sum_d + s5_sq_q[d];
    slide_d = contact_q[4] && (sum_d > (2*DW)'(s5_ssq_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        // slip gap products
        s1_pa_q[d]   <= (2*DW-1)'(mag_f(acc_i[d])) * (2*DW-1)'(time_step_i);
        s1_po_q[d]   <= (2*DW-1)'(mag_f(old_i[d])) * (2*DW-1)'(time_step_i);
        s1_na_q[d]   <= acc_i[d][DW-1];
        s1_no_q[d]   <= old_i[d][DW-1];
        s1_vel_q[d]  <= vel_i[d];
        s1_used_q[d] <= contact_i && (2'(d) < dims_i);

        s2_g_q[d]    <= sat_sub_f(
                          sat_add_f(s1_vel_q[d],
                                    sat_mag_f(s1_na_q[d], {1'b0, s1_pa_q[d]} >> FB)),
                          sat_mag_f(s1_no_q[d], {1'b0, s1_po_q[d]} >> (FB+1)));
        s2_used_q[d] <= s1_used_q[d];

        s3_pg_q[d]   <= (2*DW-1)'(mag_f(s2_g_q[d])) * (2*DW-1)'(s2_imp_q);
        s3_ng_q[d]   <= s2_g_q[d][DW-1];
        s3_used_q[d] <= s2_used_q[d];

        s4_t_q[d]    <= s3_used_q[d] ?
                        sat_mag_f(s3_ng_q[d], {1'b0, s3_pg_q[d]} >> (FB+1)) : '0;

        s5_sq_q[d]   <= (2*DW)'(mag_f(s4_t_q[d])) * (2*DW)'(mag_f(s4_t_q[d]));
        s5_num_q[d]  <= (2*DW-1)'(mag_f(s4_t_q[d])) * (2*DW-1)'(s4_str_q);
        s5_t_q[d]    <= s4_t_q[d];
      end
      s1_imp_q <= imp_i;
      s1_str_q <= str_i;
      s2_imp_q <= s1_imp_q;
      s2_str_q <= s1_str_q;
      s3_str_q <= s2_str_q;
      s4_str_q <= s3_str_q;
      s5_ssq_q <= (2*DW-2)'(s4_str_q) * (2*DW-2)'(s4_str_q);

      sum_q   <= sum_d;
      t_q     <= s5_t_q;
      num_q   <= s5_num_q;
      slide_q <= slide_d;
      stick_q <= contact_q[4] && !slide_d;
    end
  end

  assign t_o   = t_q;
  assign num_o = num_q;
  assign sum_o = sum_q;
  assign ctl_o = '{vld: vld_q[5], slide: slide_q, stick: stick_q};

endmodule

// ===== sv/cfrm_sqrt_cell.sv =====
module cfrm_sqrt_cell
  import cfrm_pkg::*;
#(
  parameter int DW = 32,
  parameter int PW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [DW+1:0]   rem_i,
  input  logic [DW-1:0]   root_i,
  input  logic [2*DW-1:0] rad_i,
  input  logic [PW-1:0]   pay_i,
  input  cfrm_ctl_t       ctl_i,
  output logic [DW+1:0]   rem_o,
  output logic [DW-1:0]   root_o,
  output logic [2*DW-1:0] rad_o,
  output logic [PW-1:0]   pay_o,
  output cfrm_ctl_t       ctl_o
);

  logic [DW+1:0]   rem_s, trial, rem_d, rem_q;
  logic            ge;
  logic [DW-1:0]   root_q;
  logic [2*DW-1:0] rad_q;
  logic [PW-1:0]   pay_q;
  cfrm_ctl_t       ctl_q;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_s = {rem_i[DW-1:0], rad_i[2*DW-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = rem_s >= trial;
    rem_d = ge ? rem_s - trial : rem_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= {root_i[DW-2:0], ge};
      rad_q  <= {rad_i[2*DW-3:0], 2'b00};
      pay_q  <= pay_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
  assign pay_o  = pay_q;
  assign ctl_o  = ctl_q;

endmodule

// ===== sv/cfrm_div_cell.sv =====
module cfrm_div_cell
  import cfrm_pkg::*;
#(
  parameter int DW = 32,
  parameter int PW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [DW-1:0]                 norm_i,
  input  logic [NUM_DIMS-1:0][2*DW-2:0] w_i,
  input  logic [PW-1:0]                 pay_i,
  input  cfrm_ctl_t                     ctl_i,
  output logic [DW-1:0]                 norm_o,
  output logic [NUM_DIMS-1:0][2*DW-2:0] w_o,
  output logic [PW-1:0]                 pay_o,
  output cfrm_ctl_t                     ctl_o
);

  // each lane word is {partial remainder, dividend bits left / quotient bits}
  logic [NUM_DIMS-1:0][2*DW-2:0] w_d, w_q;
  logic [DW:0]                   rs, rd;
  logic                          ge;
  logic [DW-1:0]                 norm_q;
  logic [PW-1:0]                 pay_q;
  cfrm_ctl_t                     ctl_q;

  always_comb begin
    rs = '0;
    rd = '0;
    ge = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      rs     = {w_i[d][2*DW-2:DW-1], w_i[d][DW-2]};
      ge     = rs >= {1'b0, norm_i};
      rd     = ge ? rs - {1'b0, norm_i} : rs;
      w_d[d] = {rd[DW-1:0], w_i[d][DW-3:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q    <= w_d;
      norm_q <= norm_i;
      pay_q  <= pay_i;
    end
  end

  assign w_o    = w_q;
  assign norm_o = norm_q;
  assign pay_o  = pay_q;
  assign ctl_o  = ctl_q;

endmodule

// ===== sv/coulomb_friction_return_map.sv =====
// Coulomb friction return map, fully pipelined: one node pair word enters per
// cycle while the pipeline is not stalled. Each word passes a front end of
// products and saturation, then a row of DATA_WIDTH square-root cells giving
// one norm bit each, then DATA_WIDTH-1 divider cells giving one bit of all
// three scaled components each, then the output register. The pipeline stalls
// only while a finished word waits on m_axis_tready; the user must write
// configuration only while the pipeline is empty; no logic enforces it.
module coulomb_friction_return_map
  import cfrm_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // impedance, strength, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z,
  // old_acc_x, old_acc_y, old_acc_z, zero pad
  input  logic [((2*(DATA_WIDTH-1)+9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // in_contact
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // traction_x, traction_y, traction_z, zero pad
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // sticking
  output logic                    m_axis_tuser,
  input  logic                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [DATA_WIDTH-2:0]   cfg_wdata_i
);

  localparam int DW      = DATA_WIDTH;
  localparam int OFF_STR = DW - 1;
  localparam int OFF_VEC = 2 * (DW - 1);
  localparam int TPW     = NUM_DIMS * DW;
  localparam int SPW     = TPW + NUM_DIMS * (2*DW - 1);

  logic          en;
  logic [DW-2:0] ts_q;
  logic [1:0]    dims_q;

  logic [NUM_DIMS-1:0][DW-1:0] vel, acc, old;

  logic [NUM_DIMS-1:0][DW-1:0]   fr_t;
  logic [NUM_DIMS-1:0][2*DW-2:0] fr_num;
  logic [2*DW-1:0]               fr_sum;
  cfrm_ctl_t                     fr_ctl;

  logic [DW+1:0]   sq_rem  [DW+1];
  logic [DW-1:0]   sq_root [DW+1];
  logic [2*DW-1:0] sq_rad  [DW+1];
  logic [SPW-1:0]  sq_pay  [DW+1];
  cfrm_ctl_t       sq_ctl  [DW+1];

  logic [NUM_DIMS-1:0][2*DW-2:0] dv_w    [DW];
  logic [DW-1:0]                 dv_norm [DW];
  logic [TPW-1:0]                dv_pay  [DW];
  cfrm_ctl_t                     dv_ctl  [DW];

  logic [NUM_DIMS-1:0][DW-1:0] trac_d, trac_q;
  logic [DW-1:0]               tv, qv;
  logic                        out_vld_q, stick_q;

  assign en            = !(out_vld_q && !m_axis_tready);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= (DW-1)'(TIME_STEP_RESET);
      dims_q <= DIMS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TIME_STEP: ts_q   <= cfg_wdata_i;
        REG_DIMS:      dims_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      vel[d] = s_axis_tdata[OFF_VEC + d*DW +: DW];
      acc[d] = s_axis_tdata[OFF_VEC + (NUM_DIMS + d)*DW +: DW];
      old[d] = s_axis_tdata[OFF_VEC + (2*NUM_DIMS + d)*DW +: DW];
    end
  end

  cfrm_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_vld_i    (s_axis_tvalid),
    .contact_i   (s_axis_tuser),
    .dims_i      (dims_q),
    .time_step_i (ts_q),
    .imp_i       (s_axis_tdata[DW-2:0]),
    .str_i       (s_axis_tdata[OFF_STR +: DW-1]),
    .vel_i       (vel),
    .acc_i       (acc),
    .old_i       (old),
    .t_o         (fr_t),
    .num_o       (fr_num),
    .sum_o       (fr_sum),
    .ctl_o       (fr_ctl)
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = fr_sum;
  assign sq_pay[0]  = {fr_num, fr_t};
  assign sq_ctl[0]  = fr_ctl;

  for (genvar i = 0; i < DW; i++) begin : g_sqrt
    cfrm_sqrt_cell #(.DW(DW), .PW(SPW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rad_i  (sq_rad[i]),
      .pay_i  (sq_pay[i]),
      .ctl_i  (sq_ctl[i]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .rad_o  (sq_rad[i+1]),
      .pay_o  (sq_pay[i+1]),
      .ctl_o  (sq_ctl[i+1])
    );
  end

  assign dv_w[0]    = sq_pay[DW][SPW-1:TPW];
  assign dv_norm[0] = sq_root[DW];
  assign dv_pay[0]  = sq_pay[DW][TPW-1:0];
  assign dv_ctl[0]  = sq_ctl[DW];

  for (genvar i = 0; i < DW-1; i++) begin : g_div
    cfrm_div_cell #(.DW(DW), .PW(TPW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .norm_i (dv_norm[i]),
      .w_i    (dv_w[i]),
      .pay_i  (dv_pay[i]),
      .ctl_i  (dv_ctl[i]),
      .norm_o (dv_norm[i+1]),
      .w_o    (dv_w[i+1]),
      .pay_o  (dv_pay[i+1]),
      .ctl_o  (dv_ctl[i+1])
    );
  end

  // sliding: scaled magnitude with the traction's sign; else keep the traction
  always_comb begin
    tv = '0;
    qv = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      tv = dv_pay[DW-1][d*DW +: DW];
      qv = {1'b0, dv_w[DW-1][d][DW-2:0]};
      if (dv_ctl[DW-1].slide) trac_d[d] = tv[DW-1] ? (~qv + 1'b1) : qv;
      else                    trac_d[d] = tv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_ctl[DW-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trac_q  <= trac_d;
      stick_q <= dv_ctl[DW-1].stick;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[TPW-1:0] = trac_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = stick_q;

endmodule

// ===== sv/cfrm_checker.sv =====
`include "coulomb_friction_return_map_assert.svh"

module cfrm_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [((3*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  input logic                                  m_axis_tuser
);

  // a stalled result word holds
  `CFRM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  // input backpressure comes only from a waiting result word
  `CFRM_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // a taken result frees the pipeline in the same cycle
  `CFRM_ASSERT_NOW(a_drain_ready, m_axis_tvalid && m_axis_tready, s_axis_tready, "input not ready while result word is taken")

endmodule

bind coulomb_friction_return_map cfrm_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cfrm_checker (.*);
